>>> design/btlv_pkg.sv
// Shared types and constants for the BER TLV stream decoder.
// Holds result kinds, error codes, the queue entry layout and queue sizing.
// No dependencies.
package btlv_pkg;

   localparam int DEFAULT_MAX_LENGTH_BYTES = 4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_VALUE  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [1:0] ERR_MULTI_TAG  = 2'd0;
   localparam logic [1:0] ERR_INDEFINITE = 2'd1;
   localparam logic [1:0] ERR_LEN_LONG   = 2'd2;
   localparam logic [1:0] ERR_EARLY_END  = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  tag;
      logic [31:0] length;
      logic [7:0]  value;
      logic        last;
      logic [1:0]  code;
      logic        tail_err;
   } btlv_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } btlv_qstat_type;

endpackage

>>> design/btlv_front.sv
// Front end of the BER TLV stream decoder: accepts bytes and tracks the parse.
// Pushes one queue entry per byte that causes results. Depends on btlv_pkg.
module btlv_front
   import btlv_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = DEFAULT_MAX_LENGTH_BYTES
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,
   input  logic           req_tlast,
   input  btlv_qstat_type qstat,
   output logic           push_valid,
   output btlv_entry_type push_entry
);

   localparam int LEFT_W = $clog2(MAX_LENGTH_BYTES + 1);

   localparam logic [2:0] PH_TAG       = 3'd0;
   localparam logic [2:0] PH_LEN_FIRST = 3'd1;
   localparam logic [2:0] PH_LEN_MORE  = 3'd2;
   localparam logic [2:0] PH_VALUE     = 3'd3;
   localparam logic [2:0] PH_DROP      = 3'd4;

   logic [2:0]        phase_ff, phase_in;
   logic [7:0]        tag_ff, tag_in;
   logic [31:0]       acc_ff, acc_in;
   logic [LEFT_W-1:0] len_left_ff, len_left_in;
   logic [31:0]       val_left_ff, val_left_in;

   logic              accept;
   logic              emit;
   btlv_entry_type    entry;
   logic [31:0]       fin_len;
   logic              fin;
   logic [31:0]       more_acc;
   logic [LEFT_W-1:0] left_dec;
   logic              val_last;

   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;
   assign more_acc   = {acc_ff[23:0], req_tdata};
   assign left_dec   = (len_left_ff != '0) ? len_left_ff - LEFT_W'(1) : '0;
   assign val_last   = (val_left_ff <= 32'd1);

   always_comb begin
      phase_in    = phase_ff;
      tag_in      = tag_ff;
      acc_in      = acc_ff;
      len_left_in = len_left_ff;
      val_left_in = val_left_ff;
      emit        = 1'b0;
      fin         = 1'b0;
      fin_len     = acc_ff;
      entry       = '0;
      entry.tag   = tag_ff;
      unique case (phase_ff)
         PH_TAG: begin
            tag_in    = req_tdata;
            entry.tag = req_tdata;
            if (req_tdata[4:0] == 5'h1f) begin
               emit       = 1'b1;
               entry.kind = KIND_ERROR;
               entry.code = ERR_MULTI_TAG;
               phase_in   = req_tlast ? PH_TAG : PH_DROP;
            end else if (req_tlast) begin
               emit       = 1'b1;
               entry.kind = KIND_ERROR;
               entry.code = ERR_EARLY_END;
               phase_in   = PH_TAG;
            end else begin
               phase_in = PH_LEN_FIRST;
            end
         end
         PH_LEN_FIRST: begin
            if (!req_tdata[7]) begin
               fin     = 1'b1;
               fin_len = {24'd0, req_tdata};
            end else if (req_tdata == 8'h80) begin
               emit       = 1'b1;
               entry.kind = KIND_ERROR;
               entry.code = ERR_INDEFINITE;
               phase_in   = req_tlast ? PH_TAG : PH_DROP;
            end else if (req_tdata[6:0] > 7'(MAX_LENGTH_BYTES)) begin
               emit       = 1'b1;
               entry.kind = KIND_ERROR;
               entry.code = ERR_LEN_LONG;
               phase_in   = req_tlast ? PH_TAG : PH_DROP;
            end else begin
               len_left_in = req_tdata[LEFT_W-1:0];
               acc_in      = '0;
               if (req_tlast) begin
                  emit       = 1'b1;
                  entry.kind = KIND_ERROR;
                  entry.code = ERR_EARLY_END;
                  phase_in   = PH_TAG;
               end else begin
                  phase_in = PH_LEN_MORE;
               end
            end
         end
         PH_LEN_MORE: begin
            acc_in      = more_acc;
            len_left_in = left_dec;
            if (left_dec == '0) begin
               fin     = 1'b1;
               fin_len = more_acc;
            end else if (req_tlast) begin
               emit       = 1'b1;
               entry.kind = KIND_ERROR;
               entry.code = ERR_EARLY_END;
               phase_in   = PH_TAG;
            end
         end
         PH_VALUE: begin
            emit         = 1'b1;
            entry.kind   = KIND_VALUE;
            entry.length = acc_ff;
            entry.value  = req_tdata;
            entry.last   = val_last;
            if (val_last) begin
               val_left_in = '0;
               phase_in    = PH_TAG;
            end else begin
               val_left_in    = val_left_ff - 32'd1;
               entry.tail_err = req_tlast;
               if (req_tlast) begin
                  phase_in = PH_TAG;
               end
            end
         end
         PH_DROP: begin
            phase_in = req_tlast ? PH_TAG : PH_DROP;
         end
         default: begin
            phase_in = PH_TAG;
         end
      endcase
      if (fin) begin
         acc_in       = fin_len;
         emit         = 1'b1;
         entry.kind   = KIND_HEADER;
         entry.length = fin_len;
         if (fin_len == 32'd0) begin
            phase_in = PH_TAG;
         end else begin
            val_left_in    = fin_len;
            entry.tail_err = req_tlast;
            phase_in       = req_tlast ? PH_TAG : PH_VALUE;
         end
      end
   end

   assign push_valid = accept && emit;
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TAG;
         tag_ff      <= '0;
         acc_ff      <= '0;
         len_left_ff <= '0;
         val_left_ff <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         tag_ff      <= tag_in;
         acc_ff      <= acc_in;
         len_left_ff <= len_left_in;
         val_left_ff <= val_left_in;
      end
   end

endmodule

>>> design/btlv_queue.sv
// Short first-in first-out queue between the decoder's front and back ends.
// Holds pending result entries. Depends on btlv_pkg.
module btlv_queue
   import btlv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  btlv_entry_type push_entry,
   output btlv_qstat_type qstat,
   output logic           pop_valid,
   input  logic           pop_ready,
   output btlv_entry_type pop_entry
);

   btlv_entry_type         mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign qstat.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_valid   = !qstat.empty;
   assign pop_entry   = mem_ff[rd_ptr_ff];
   assign do_push     = push_valid && !qstat.full;
   assign do_pop      = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> design/btlv_back.sv
// Back end of the BER TLV stream decoder: turns queue entries into results.
// Adds the trailing early-end error where an entry asks for it. Depends on btlv_pkg.
module btlv_back
   import btlv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           pop_valid,
   output logic           pop_ready,
   input  btlv_entry_type pop_entry,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [55:0]    rsp_tdata,
   output logic           rsp_tlast,
   output logic [1:0]     rsp_tuser
);

   logic           valid_ff, valid_in;
   logic           tail_ff, tail_in;
   btlv_entry_type out_ff, out_in;
   logic           load;

   assign load      = !valid_ff || rsp_tready;
   assign pop_ready = load && !tail_ff;

   always_comb begin
      valid_in = valid_ff;
      tail_in  = tail_ff;
      out_in   = out_ff;
      if (load) begin
         if (tail_ff) begin
            out_in      = '0;
            out_in.kind = KIND_ERROR;
            out_in.tag  = out_ff.tag;
            out_in.code = ERR_EARLY_END;
            valid_in    = 1'b1;
            tail_in     = 1'b0;
         end else if (pop_valid) begin
            out_in   = pop_entry;
            valid_in = 1'b1;
            tail_in  = pop_entry.tail_err;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tail_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tail_ff  <= tail_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.code, out_ff.value, out_ff.length, out_ff.tag};
   assign rsp_tlast  = out_ff.last;
   assign rsp_tuser  = out_ff.kind;

endmodule

>>> design/ber_tlv_stream_decoder.sv
// Top level of the BER TLV stream decoder.
// Instantiates btlv_front, btlv_queue and btlv_back; depends on btlv_pkg.
//
// The request channel carries one encoded byte per request, with tlast on
// the last byte of a buffer. The response channel carries header, value and
// error results; tuser gives the kind, tlast marks the final content byte.
// An accepted byte is parsed in its cycle of acceptance; its first result is
// registered in the queue and then in the output register. One byte is
// accepted per clock while the queue is not full. A byte that ends a buffer
// inside an element gives two results, its own and an early-end error; a
// four-entry queue before the output register absorbs these and short stalls.
// When the receiver holds tready low, the output register holds its result
// and the queue fills; req_tready drops only once the queue is full.
// A synchronous reset clears the queue and output register and returns the
// parser to awaiting a tag byte.
module ber_tlv_stream_decoder
   import btlv_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = DEFAULT_MAX_LENGTH_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // tag_byte, content_length, value_byte, error_code
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser    // kind
);

   btlv_qstat_type qstat;
   logic           push_valid;
   btlv_entry_type push_entry;
   logic           pop_valid;
   logic           pop_ready;
   btlv_entry_type pop_entry;

   btlv_front #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .qstat      (qstat),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   btlv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .qstat      (qstat),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   btlv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   a_queue_state : assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("queue reports full and empty at once");

   a_push_room : assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !qstat.full)
      else $error("entry pushed into a full queue");

   a_last_is_value : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == KIND_VALUE))
      else $error("last flag set on a result that is not a value byte");

   a_error_no_length : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_ERROR) |-> (rsp_tdata[39:8] == 32'd0))
      else $error("error result carries a nonzero length");

endmodule
